// ===== src/gradient_noise_3d_assert.svh =====
// Assertion macros for the gradient noise block.
`ifndef GRADIENT_NOISE_3D_ASSERT_SVH
`define GRADIENT_NOISE_3D_ASSERT_SVH

// same-cycle implication
`define GN3D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GN3D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/gn3d_pkg.sv =====
// Types, constants and arithmetic helpers for the gradient noise block.
package gn3d_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int FRAC_W = 16;
    localparam int FADE_W = 17;
    localparam int VAL_W = 18;
    localparam int GRAD_W = VAL_W + 1;
    localparam int TVAL_W = 8;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_Z = 2'd2;

    localparam logic signed [VAL_W-1:0] NOISE_MAX = 18'sd131071;
    localparam logic signed [VAL_W-1:0] NOISE_MIN = -18'sd131072;

    typedef logic [FRAC_W-1:0] frac_t;
    typedef logic [FADE_W-1:0] fade_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [GRAD_W-1:0] grad_t;
    typedef logic [TVAL_W-1:0] tval_t;

    // corner sums reach +/-2^17, one bit past the output range
    function automatic grad_t grad(input logic [3:0] h, input val_t dx, input val_t dy,
                                   input val_t dz);
        logic signed [GRAD_W-1:0] r;
        unique case (h)
            4'd0:  r = dx + dy;
            4'd1:  r = dy - dx;
            4'd2:  r = dx - dy;
            4'd3:  r = -dx - dy;
            4'd4:  r = dx + dz;
            4'd5:  r = dz - dx;
            4'd6:  r = dx - dz;
            4'd7:  r = -dx - dz;
            4'd8:  r = dy + dz;
            4'd9:  r = dz - dy;
            4'd10: r = dy - dz;
            4'd11: r = -dy - dz;
            4'd12: r = dx + dy;
            4'd13: r = dy - dx;
            4'd14: r = dz - dy;
            default: r = -dy - dz;
        endcase
        return r;
    endfunction

    // a + round_half_up((b - a) * s / 2^16)
    function automatic grad_t lerp(input grad_t a, input grad_t b, input fade_t s);
        logic signed [GRAD_W:0] diff;
        logic signed [GRAD_W+FADE_W+1:0] prod;
        logic signed [GRAD_W+FADE_W+1:0] step;
        logic signed [GRAD_W+FADE_W+1:0] sum;
        diff = {b[GRAD_W-1], b} - {a[GRAD_W-1], a};
        prod = (GRAD_W+FADE_W+2)'(diff) * $signed({2'b00, s});
        step = (prod + 32768) >>> FRAC_W;
        sum = step + (GRAD_W+FADE_W+2)'(a);
        return sum[GRAD_W-1:0];
    endfunction

endpackage

// ===== src/gradient_noise_3d.sv =====
// Top level of the pipelined 3D gradient noise evaluator.
//
// channel  | handshake          | payload
// s_       | s_valid / s_ready  | func, table_select, table_index, table_value, coord_x/y/z
// m_       | m_valid / m_ready  | noise_value, is_noise
//
// One request per cycle unless m_ready stalls the pipe; six register stages, result presented from stage six.
// Stage one reads the three permutation tables (two read ports each) and starts the fade.
// Loads write the table at acceptance, so later evaluates see them in order.
// A stage fills when empty or when the next stage moves; bubbles collapse under stall.
// Reset clears only the valid bits; table contents are undefined until written.
module gradient_noise_3d #(
    parameter int TABLE_SIZE = gn3d_pkg::TABLE_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [1:0]                    s_table_select,
    input  logic [7:0]                    s_table_index,
    input  logic [7:0]                    s_table_value,
    input  logic signed [31:0]            s_coord_x,
    input  logic signed [31:0]            s_coord_y,
    input  logic signed [31:0]            s_coord_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [17:0]            m_noise_value,
    output logic                          m_is_noise
);
    import gn3d_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);

    logic [6:1] v_reg;
    logic [6:1] en;
    logic [6:1] eval_reg;

    logic [IW-1:0] cidx [3];
    frac_t         fin  [3];
    logic          acc;
    logic [2:0]    wr_en;

    tval_t mem_x [TABLE_SIZE];
    tval_t mem_y [TABLE_SIZE];
    tval_t mem_z [TABLE_SIZE];
    tval_t rd_reg [3][2];

    frac_t         f1_reg  [3];
    logic [19:0]   fu1_reg [3];
    frac_t         t21_reg [3];
    logic [19:0]   c2_reg  [3];
    frac_t         t32_reg [3];
    grad_t         g2_reg  [8];
    fade_t         s3_reg  [3];
    grad_t         g3_reg  [8];
    grad_t         lx4_reg [4];
    fade_t         s4_reg  [2];
    grad_t         ly5_reg [2];
    fade_t         s5_reg;
    val_t          out_reg;

    grad_t         lz;
    logic [19:0]   u_in    [3];
    logic [35:0]   fu_full [3];
    logic [31:0]   t2_full [3];
    logic [31:0]   t3_full [3];
    logic [35:0]   s_full  [3];
    val_t          dn      [3];
    val_t          df      [3];
    logic [3:0]    hsh     [8];

    always_comb begin
        en[6] = !v_reg[6] || m_ready;
        for (int i = 5; i >= 1; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end
    assign s_ready = en[1];
    assign acc = s_valid && en[1];

    assign fin[0] = s_coord_x[15:0];
    assign fin[1] = s_coord_y[15:0];
    assign fin[2] = s_coord_z[15:0];
    assign cidx[0] = s_coord_x[16 +: IW];
    assign cidx[1] = s_coord_y[16 +: IW];
    assign cidx[2] = s_coord_z[16 +: IW];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wr_en[k] = acc && (s_func == FUNC_LOAD)
                && (32'(s_table_index) < 32'(TABLE_SIZE));
        end
        wr_en[0] = wr_en[0] && (s_table_select == SEL_X);
        wr_en[1] = wr_en[1] && (s_table_select == SEL_Y);
        wr_en[2] = wr_en[2] && (s_table_select == SEL_Z);
    end

    always_ff @(posedge aclk) begin
        if (wr_en[0]) mem_x[IW'(s_table_index)] <= s_table_value;
        if (wr_en[1]) mem_y[IW'(s_table_index)] <= s_table_value;
        if (wr_en[2]) mem_z[IW'(s_table_index)] <= s_table_value;
        if (en[1]) begin
            rd_reg[0][0] <= mem_x[cidx[0]];
            rd_reg[0][1] <= mem_x[cidx[0] + 1'b1];
            rd_reg[1][0] <= mem_y[cidx[1]];
            rd_reg[1][1] <= mem_y[cidx[1] + 1'b1];
            rd_reg[2][0] <= mem_z[cidx[2]];
            rd_reg[2][1] <= mem_z[cidx[2] + 1'b1];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            u_in[k]    = 20'd983040 - 20'(fin[k]) * 20'd6;
            fu_full[k] = 36'(fin[k]) * 36'(u_in[k]);
            t2_full[k] = 32'(fin[k]) * 32'(fin[k]);
            t3_full[k] = 32'(t21_reg[k]) * 32'(f1_reg[k]);
            s_full[k]  = 36'(t32_reg[k]) * 36'(c2_reg[k]);
            dn[k]      = $signed({2'b00, f1_reg[k]});
            df[k]      = $signed({2'b11, f1_reg[k]});
        end
        for (int j = 0; j < 8; j++) begin
            hsh[j] = rd_reg[0][j & 1][3:0] ^ rd_reg[1][(j >> 1) & 1][3:0]
                   ^ rd_reg[2][(j >> 2) & 1][3:0];
        end
        lz = lerp(ly5_reg[0], ly5_reg[1], s5_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 6; i >= 2; i--) begin
                if (en[i]) v_reg[i] <= v_reg[i-1];
            end
            if (en[1]) v_reg[1] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            eval_reg[1] <= s_func;
            for (int k = 0; k < 3; k++) begin
                f1_reg[k]  <= fin[k];
                fu1_reg[k] <= fu_full[k][35:16];
                t21_reg[k] <= t2_full[k][31:16];
            end
        end
        if (en[2]) begin
            eval_reg[2] <= eval_reg[1];
            for (int k = 0; k < 3; k++) begin
                c2_reg[k]  <= 20'd655360 - fu1_reg[k];
                t32_reg[k] <= t3_full[k][31:16];
            end
            for (int j = 0; j < 8; j++) begin
                g2_reg[j] <= grad(hsh[j],
                                  ((j & 1) != 0) ? df[0] : dn[0],
                                  ((j & 2) != 0) ? df[1] : dn[1],
                                  ((j & 4) != 0) ? df[2] : dn[2]);
            end
        end
        if (en[3]) begin
            eval_reg[3] <= eval_reg[2];
            for (int k = 0; k < 3; k++) s3_reg[k] <= s_full[k][32:16];
            for (int j = 0; j < 8; j++) g3_reg[j] <= g2_reg[j];
        end
        if (en[4]) begin
            eval_reg[4] <= eval_reg[3];
            for (int j = 0; j < 4; j++) begin
                lx4_reg[j] <= lerp(g3_reg[2*j], g3_reg[2*j+1], s3_reg[0]);
            end
            s4_reg[0] <= s3_reg[1];
            s4_reg[1] <= s3_reg[2];
        end
        if (en[5]) begin
            eval_reg[5] <= eval_reg[4];
            ly5_reg[0] <= lerp(lx4_reg[0], lx4_reg[1], s4_reg[0]);
            ly5_reg[1] <= lerp(lx4_reg[2], lx4_reg[3], s4_reg[0]);
            s5_reg <= s4_reg[1];
        end
        if (en[6]) begin
            eval_reg[6] <= eval_reg[5];
            if (eval_reg[5] == FUNC_EVAL) begin
                if (lz > grad_t'(NOISE_MAX)) begin
                    out_reg <= NOISE_MAX;
                end else if (lz < grad_t'(NOISE_MIN)) begin
                    out_reg <= NOISE_MIN;
                end else begin
                    out_reg <= lz[VAL_W-1:0];
                end
            end else begin
                out_reg <= '0;
            end
        end
    end

    assign m_valid       = v_reg[6];
    assign m_noise_value = out_reg;
    assign m_is_noise    = eval_reg[6];

`include "gradient_noise_3d_assert.svh"

    `GN3D_ASSERT_NOW(a_load_zero, aclk, aresetn, m_valid && !m_is_noise, m_noise_value == 0, "load ack with nonzero value")
    `GN3D_ASSERT_NOW(a_ready_free, aclk, aresetn, !m_valid, s_ready, "input blocked while output empty")
    `GN3D_ASSERT_NEXT(a_enter, aclk, aresetn, s_valid && s_ready, v_reg[1], "accepted request lost at stage one")

endmodule
